FILE: hdl/xss_pkg.sv
// Package for the xoshiro short scalar sampler: sizes, constants, types and the seed helper.
package xss_pkg;

  // Number of 32-bit words in one scalar (legal range 1 to 8).
  localparam int unsigned SCALAR_WORDS = 8;

  // Largest bit length of a scalar, and the widths that follow from it.
  localparam int unsigned MAX_BITS = SCALAR_WORDS * 32;
  localparam int unsigned BITS_W   = $clog2(MAX_BITS + 1);
  localparam int unsigned FULL_W   = BITS_W - 5;
  localparam int unsigned IDX_W    = (SCALAR_WORDS > 1) ? $clog2(SCALAR_WORDS) : 1;

  // Widths of the fields on the ports.
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WIDX_W   = 3;

  // Seed chain constants.
  localparam logic [31:0] SEED_XOR = 32'hDEADBEEF;
  localparam logic [31:0] CHAIN_C1 = 32'h9E3779B9;
  localparam logic [31:0] CHAIN_C2 = 32'h6C62272E;
  localparam logic [31:0] CHAIN_C3 = 32'h08DB8267;

  // Reset value of the bit length register.
  localparam logic [CFG_W-1:0] SCALAR_BITS_RST = 9'd128;

  // Input actions.
  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  // Generator state: four 32-bit words, word 0 in the lowest slot.
  typedef logic [3:0][31:0] gen_state_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_EMIT
  } xss_state_e;

  // Derives the full generator state from one entropy word.
  function automatic gen_state_t seed_words(input logic [31:0] entropy);
    gen_state_t s;
    s[0] = entropy ^ SEED_XOR;
    s[1] = s[0] ^ CHAIN_C1;
    s[2] = s[1] ^ CHAIN_C2;
    s[3] = s[2] ^ CHAIN_C3;
    return s;
  endfunction

endpackage

FILE: hdl/xoshiro_short_scalar_sampler.sv
// Top level of the xoshiro short scalar sampler: sequencer, shared generator step and word buffer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_data_i (scalar bit length)
//  in      | in        | in_valid_i / in_stall_o    | in_action_i, in_entropy_i
//  out     | out       | out_valid_o / out_stall_i  | out_word_o, out_word_index_o,
//          |           |                            | out_bit_count_o, out_last_o
//
// A reseed word reseeds the generator and gives no result. An accepted draw word starts a
// generation pass that fills the buffer word by word (one shared xoshiro128** step unit), then
// an emission pass that sends each word while the output is not stalled; the next input word is
// taken only once the last word has gone.
// Reset seeds the generator as if with zero entropy and sets the bit length to 128.
// Output stalls hold the current word; the input stays stalled until the last word goes.
module xoshiro_short_scalar_sampler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [xss_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_action_i,
  input  logic [31:0]                  in_entropy_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [xss_pkg::WORD_W-1:0]   out_word_o,
  output logic [xss_pkg::WIDX_W-1:0]   out_word_index_o,
  output logic [xss_pkg::CFG_W-1:0]    out_bit_count_o,
  output logic                         out_last_o
);
  import xss_pkg::*;

  xss_state_e          state_q, state_d;
  gen_state_t          gen_q, gen_d;
  logic [CFG_W-1:0]    scalar_bits_q, scalar_bits_d;
  logic [BITS_W-1:0]   bits_q, bits_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                any_q, any_d;
  logic [31:0]         buf_q [SCALAR_WORDS];
  logic [31:0]         buf_wdata;
  logic                buf_we;

  logic [BITS_W-1:0]   cfg_bits_ext;
  logic [BITS_W-1:0]   bits_clamped;
  logic [FULL_W-1:0]   full_words;
  logic [4:0]          rem_bits;
  logic [FULL_W-1:0]   idx_ext;
  logic                idx_last;
  logic                in_accept;
  logic                out_accept;

  // Shared generator step: output word and next state.
  logic [31:0]         mul5, rot7, step_res, shl9;
  logic [31:0]         s2a, s3a, s1a, s0a, s2b, s3b;
  gen_state_t          gen_next;

  assign mul5     = gen_q[1] + (gen_q[1] << 2);
  assign rot7     = {mul5[24:0], mul5[31:25]};
  assign step_res = rot7 + (rot7 << 3);
  assign shl9     = gen_q[1] << 9;
  assign s2a      = gen_q[2] ^ gen_q[0];
  assign s3a      = gen_q[3] ^ gen_q[1];
  assign s1a      = gen_q[1] ^ s2a;
  assign s0a      = gen_q[0] ^ s3a;
  assign s2b      = s2a ^ shl9;
  assign s3b      = {s3a[20:0], s3a[31:21]};
  assign gen_next = {s3b, s2b, s1a, s0a};

  // Clamp the configured bit length into one to the scalar size.
  assign cfg_bits_ext = BITS_W'(scalar_bits_q);
  always_comb begin
    if (cfg_bits_ext > BITS_W'(MAX_BITS)) begin
      bits_clamped = BITS_W'(MAX_BITS);
    end else if (cfg_bits_ext == '0) begin
      bits_clamped = BITS_W'(1);
    end else begin
      bits_clamped = cfg_bits_ext;
    end
  end

  assign full_words = bits_q[BITS_W-1:5];
  assign rem_bits   = bits_q[4:0];
  assign idx_ext    = FULL_W'(idx_q);
  assign idx_last   = (idx_q == IDX_W'(SCALAR_WORDS - 1));

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_accept  = out_valid_o && !out_stall_i;

  // Output word comes straight from the buffer; an all-zero scalar shows 1 in word 0.
  assign out_word_o       = (idx_q == '0 && !any_q) ? 32'd1 : buf_q[idx_q];
  assign out_word_index_o = WIDX_W'(idx_q);
  assign out_bit_count_o  = CFG_W'(bits_q);
  assign out_last_o       = idx_last;

  // Sequencer: next state, counters and the buffer write.
  always_comb begin
    state_d       = state_q;
    gen_d         = gen_q;
    scalar_bits_d = scalar_bits_q;
    bits_d        = bits_q;
    idx_d         = idx_q;
    any_d         = any_q;
    buf_we        = 1'b0;
    buf_wdata     = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      scalar_bits_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_action_i == ACT_RESEED) begin
            gen_d = seed_words(in_entropy_i);
          end else begin
            bits_d  = bits_clamped;
            idx_d   = '0;
            any_d   = 1'b0;
            state_d = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        // Full words take a step, a partial top word a masked step, the rest are zero.
        buf_we = 1'b1;
        if (idx_ext < full_words) begin
          buf_wdata = step_res;
          gen_d     = gen_next;
        end else if (idx_ext == full_words && rem_bits != '0) begin
          buf_wdata = step_res & ~(32'hFFFF_FFFF << rem_bits);
          gen_d     = gen_next;
        end else begin
          buf_wdata = '0;
        end
        any_d = any_q | (buf_wdata != '0);
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_accept) begin
          if (idx_last) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and generator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      gen_q         <= seed_words(32'h0);
      scalar_bits_q <= SCALAR_BITS_RST;
      bits_q        <= BITS_W'(1);
      idx_q         <= '0;
      any_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      gen_q         <= gen_d;
      scalar_bits_q <= scalar_bits_d;
      bits_q        <= bits_d;
      idx_q         <= idx_d;
      any_q         <= any_d;
    end
  end

  // Scalar word buffer, written one word per generation cycle.
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[idx_q] <= buf_wdata;
    end
  end

  // No new input word is taken while a scalar is being emitted.
  a_busy_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while emitting");

  // An accepted draw keeps the input stalled on the next cycle.
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_action_i == ACT_DRAW) |=> (in_stall_o && !out_valid_o))
    else $error("draw did not start generation");

  // Taking the last word ends the emission.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && out_last_o) |=> !out_valid_o)
    else $error("emission continued after the last word");

  // An all-zero scalar shows 1 in its lowest word.
  a_zero_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !any_q && out_word_index_o == '0) |-> (out_word_o == 32'd1))
    else $error("all-zero scalar not forced to one");

endmodule
